// ===== hw/rtl/ski_pkg.sv =====
package ski_pkg;

	localparam int MAX_BASES_DEF = 64;

	// field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int STEP_W = 6;
	localparam int BASE_W = 2;

	// padded base position: split + step + pad stays below 512
	localparam int POS_W = 9;

	localparam logic [BASE_W-1:0] BASE_MASK = 2'b11;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_CHECK,
		ST_READ,
		ST_EMIT
	} ski_state_t;

	typedef struct packed {
		logic take;
		logic clr_step;
		logic rd_en;
		logic adv_step;
	} ski_cmd_t;

	typedef struct packed {
		logic last_byte;
		logic steps_zero;
		logic last_step;
	} ski_status_t;

endpackage

// ===== hw/rtl/ski_ctrl.sv =====
module ski_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 out_ready,
	input  ski_pkg::ski_status_t st,
	output logic                 in_ready,
	output logic                 out_valid,
	output ski_pkg::ski_cmd_t    cmd
);
	import ski_pkg::*;

	ski_state_t state_q;
	ski_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (st.last_byte) begin
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.clr_step = 1'b1;
				state_nxt = st.steps_zero ? ST_COLLECT : ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.last_step) begin
						state_nxt = ST_COLLECT;
					end else begin
						cmd.adv_step = 1'b1;
						state_nxt = ST_READ;
					end
				end
			end
			default: begin
				state_nxt = ST_COLLECT;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ski_datapath.sv =====
module ski_datapath #(
	parameter int MAX_BASES = ski_pkg::MAX_BASES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ski_pkg::ski_cmd_t           cmd,
	output ski_pkg::ski_status_t        st,
	input  logic [ski_pkg::BYTE_W-1:0]  seq_byte,
	input  logic [ski_pkg::LEN_W-1:0]   seq_length,
	input  logic [ski_pkg::LEN_W-1:0]   split_position,
	input  logic                        last_byte,
	output logic [ski_pkg::LEN_W-1:0]   prefix_length,
	output logic [ski_pkg::LEN_W-1:0]   suffix_length,
	output logic [ski_pkg::STEP_W-1:0]  step_index,
	output logic [ski_pkg::BASE_W-1:0]  suffix_base,
	output logic [ski_pkg::BASE_W-1:0]  prefix_base,
	output logic                        last_result
);
	import ski_pkg::*;

	localparam int STORE_BYTES = (MAX_BASES + 3) / 4;
	localparam int IDX_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CNT_W = $clog2(STORE_BYTES + 1);
	localparam logic [POS_W:0] MAX_LEN = (POS_W+1)'(MAX_BASES);
	localparam logic [POS_W-3:0] STORE_TOP = (POS_W-2)'(STORE_BYTES);

	logic [BYTE_W-1:0]      store [STORE_BYTES];
	logic [STORE_BYTES-1:0] valid_q;
	logic [STORE_BYTES-1:0] valid_nxt;
	logic [CNT_W-1:0]       cnt_q;
	logic [LEN_W-1:0]       held_len_q;
	logic [LEN_W-1:0]       held_split_q;
	logic [LEN_W-1:0]       step_q;

	logic                   first;
	logic                   room;
	logic [IDX_W-1:0]       wr_idx;
	logic [LEN_W-1:0]       len_sat;
	logic [LEN_W-1:0]       split_sat;

	logic [LEN_W-1:0]       pre;
	logic [LEN_W-1:0]       suf;
	logic [LEN_W-1:0]       steps;
	logic [1:0]             pad;
	logic [POS_W-1:0]       pos_suf;
	logic [POS_W-1:0]       pos_pre;
	logic [IDX_W-1:0]       suf_idx;
	logic [IDX_W-1:0]       pre_idx;
	logic                   suf_hit;
	logic                   pre_hit;

	logic [BYTE_W-1:0]      suf_byte_q;
	logic [BYTE_W-1:0]      pre_byte_q;
	logic [1:0]             suf_sel_q;
	logic [1:0]             pre_sel_q;
	logic                   suf_ok_q;
	logic                   pre_ok_q;

	// write side
	assign first  = (cnt_q == '0);
	assign room   = (cnt_q < CNT_W'(STORE_BYTES));
	assign wr_idx = cnt_q[IDX_W-1:0];

	always_comb begin
		len_sat = seq_length;
		if ({{(POS_W+1-LEN_W){1'b0}}, seq_length} > MAX_LEN) begin
			len_sat = LEN_W'(MAX_BASES);
		end
		split_sat = (split_position > len_sat) ? len_sat : split_position;
	end

	// entries not yet written in this record read as zero
	always_comb begin
		valid_nxt = first ? '0 : valid_q;
		if (room) begin
			valid_nxt[wr_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cnt_q        <= '0;
			held_len_q   <= '0;
			held_split_q <= '0;
			step_q       <= '0;
		end else begin
			if (cmd.take) begin
				valid_q <= valid_nxt;
				if (last_byte) begin
					cnt_q <= '0;
				end else if (room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (first) begin
					held_len_q   <= len_sat;
					held_split_q <= split_sat;
				end
			end
			if (cmd.clr_step) begin
				step_q <= '0;
			end else if (cmd.adv_step) begin
				step_q <= step_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && room) begin
			store[wr_idx] <= seq_byte;
		end
	end

	// read side, both directions out from the split
	assign pre   = held_split_q;
	assign suf   = held_len_q - held_split_q;
	assign steps = (pre > suf) ? pre : suf;
	assign pad   = 2'(2'b00 - held_len_q[1:0]);

	assign pos_suf = POS_W'(held_split_q) + POS_W'(step_q) + POS_W'(pad);
	assign pos_pre = POS_W'(held_split_q) - POS_W'(step_q) - POS_W'(1) + POS_W'(pad);
	assign suf_idx = pos_suf[IDX_W+1:2];
	assign pre_idx = pos_pre[IDX_W+1:2];
	assign suf_hit = (pos_suf[POS_W-1:2] < STORE_TOP);
	assign pre_hit = (pos_pre[POS_W-1:2] < STORE_TOP);

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			suf_byte_q <= store[suf_idx];
			pre_byte_q <= store[pre_idx];
			suf_sel_q  <= pos_suf[1:0];
			pre_sel_q  <= pos_pre[1:0];
			suf_ok_q   <= (step_q < suf) && suf_hit && valid_q[suf_idx];
			pre_ok_q   <= (step_q < pre) && pre_hit && valid_q[pre_idx];
		end
	end

	// most significant pair first
	assign suffix_base = suf_ok_q ? (BASE_W'(suf_byte_q >> {~suf_sel_q, 1'b0}) & BASE_MASK)
	                              : '0;
	assign prefix_base = pre_ok_q ? (BASE_W'(pre_byte_q >> {~pre_sel_q, 1'b0}) & BASE_MASK)
	                              : '0;

	assign prefix_length = pre;
	assign suffix_length = suf;
	assign step_index    = step_q[STEP_W-1:0];
	assign last_result   = ((step_q + LEN_W'(1)) == steps);

	assign st.last_byte  = last_byte;
	assign st.steps_zero = (steps == '0);
	assign st.last_step  = last_result;

endmodule

// ===== hw/rtl/superkmer_base_interleaver.sv =====
// superkmer_base_interleaver
//
// input channel (in_valid/in_ready): one word per packed byte of a record, four
// 2-bit bases with the most significant pair first, left-padded so the record
// ends on a byte boundary. seq_length and split_position are taken with the
// first word of a record, last_byte marks its final word. in_ready is high
// while a record is being collected, one word per cycle.
// output channel (out_valid/out_ready): after the last word, max(prefix,
// suffix) result words, one per step outward from the split, each with the
// suffix base, the prefix base and both lengths; last_result marks the end.
// after the last word is taken the block passes a check state and a store read
// before the first result word is offered; each result then takes a store read,
// then the output word. no input is taken while results are pending.
// a stalled receiver holds the current result word and the whole block.
// reset clears the per-byte valid bits and returns to collecting. each record clears
// the store through per-byte valid bits, so bytes never sent read as zero.
module superkmer_base_interleaver #(
	parameter int MAX_BASES = ski_pkg::MAX_BASES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ski_pkg::BYTE_W-1:0]  seq_byte,
	input  logic [ski_pkg::LEN_W-1:0]   seq_length,
	input  logic [ski_pkg::LEN_W-1:0]   split_position,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ski_pkg::LEN_W-1:0]   prefix_length,
	output logic [ski_pkg::LEN_W-1:0]   suffix_length,
	output logic [ski_pkg::STEP_W-1:0]  step_index,
	output logic [ski_pkg::BASE_W-1:0]  suffix_base,
	output logic [ski_pkg::BASE_W-1:0]  prefix_base,
	output logic                        last_result
);
	import ski_pkg::*;

	ski_cmd_t    cmd;
	ski_status_t st;

	ski_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.st        (st),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	ski_datapath #(
		.MAX_BASES (MAX_BASES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.seq_byte       (seq_byte),
		.seq_length     (seq_length),
		.split_position (split_position),
		.last_byte      (last_byte),
		.prefix_length  (prefix_length),
		.suffix_length  (suffix_length),
		.step_index     (step_index),
		.suffix_base    (suffix_base),
		.prefix_base    (prefix_base),
		.last_result    (last_result)
	);

endmodule

// ===== hw/rtl/ski_checker.sv =====
module ski_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        last_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ski_pkg::STEP_W-1:0]  step_index,
	input logic                        last_result
);
	import ski_pkg::*;

	// never collecting and emitting at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result word is offered");

	// the last word of a record closes the input side
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_byte) |=> !in_ready)
		else $error("input still ready after the last word of a record");

	// the final result word hands the block back to the input side
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> in_ready)
		else $error("input not ready after the final result word");

	// steps follow one another with a store read between them
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_result) |=>
			(!out_valid ##1 (out_valid && step_index == STEP_W'($past(step_index, 2) + 1))))
		else $error("result step out of sequence");

	// a held result word keeps its step
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(step_index)))
		else $error("stalled result word changed");

endmodule

bind superkmer_base_interleaver ski_checker u_ski_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_byte   (last_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.step_index  (step_index),
	.last_result (last_result)
);

// ===== bench/tb_superkmer_base_interleaver.sv =====
module tb_superkmer_base_interleaver;
	timeunit 1ns;
	timeprecision 1ps;

	import ski_pkg::*;

	localparam int STORE_DEPTH  = (MAX_BASES_DEF + 3) / 4;
	localparam int RANDOM_WORDS = 420;
	localparam int QUIET_FROM   = 365;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;

	typedef struct packed {
		logic [LEN_W-1:0]  pre_len;
		logic [LEN_W-1:0]  suf_len;
		logic [STEP_W-1:0] step;
		logic [BASE_W-1:0] suf_base;
		logic [BASE_W-1:0] pre_base;
		logic              last;
	} step_word_t;

	class outward_base_tracker;
		logic [BYTE_W-1:0] store [STORE_DEPTH];
		int unsigned       byte_cnt;
		int unsigned       rec_len;
		int unsigned       rec_split;
		step_word_t        pending_steps [$];
		int                errors;

		function new();
			foreach (store[k])
				store[k] = '0;
			byte_cnt  = 0;
			rec_len   = 0;
			rec_split = 0;
			errors    = 0;
		endfunction

		function logic [BASE_W-1:0] base_at(int unsigned pos);
			int unsigned idx;
			int unsigned sh;
			idx = pos / 4;
			sh  = (3 - pos % 4) * 2;
			if (idx >= STORE_DEPTH)
				return '0;
			return BASE_W'(store[idx] >> sh) & BASE_MASK;
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len,
				logic [LEN_W-1:0] sp, logic last);
			int unsigned pad;
			int unsigned pre;
			int unsigned suf;
			int unsigned steps;
			step_word_t  w;
			if (byte_cnt == 0) begin
				rec_len   = (len > MAX_BASES_DEF) ? MAX_BASES_DEF : len;
				rec_split = (sp > rec_len) ? rec_len : sp;
				foreach (store[k])
					store[k] = '0;
			end
			// words past the store capacity are dropped
			if (byte_cnt < STORE_DEPTH) begin
				store[byte_cnt] = b;
				byte_cnt++;
			end
			if (!last)
				return;
			byte_cnt = 0;
			pad   = (4 - rec_len % 4) % 4;
			pre   = rec_split;
			suf   = rec_len - rec_split;
			steps = (pre > suf) ? pre : suf;
			for (int unsigned i = 0; i < steps; i++) begin
				w.pre_len  = LEN_W'(pre);
				w.suf_len  = LEN_W'(suf);
				w.step     = STEP_W'(i);
				w.suf_base = (i < suf) ? base_at(rec_split + i + pad) : '0;
				w.pre_base = (i < pre) ? base_at(rec_split - 1 - i + pad) : '0;
				w.last     = (i + 1 == steps);
				pending_steps.push_back(w);
			end
		endfunction

		function void check_step(step_word_t got);
			step_word_t want;
			if (pending_steps.size() == 0) begin
				$error("result word with nothing outstanding: step_index %0d", got.step);
				errors++;
				return;
			end
			want = pending_steps.pop_front();
			if (got.pre_len !== want.pre_len) begin
				$error("prefix_length: expected %0d, got %0d", want.pre_len, got.pre_len);
				errors++;
			end
			if (got.suf_len !== want.suf_len) begin
				$error("suffix_length: expected %0d, got %0d", want.suf_len, got.suf_len);
				errors++;
			end
			if (got.step !== want.step) begin
				$error("step_index: expected %0d, got %0d", want.step, got.step);
				errors++;
			end
			if (got.suf_base !== want.suf_base) begin
				$error("suffix_base: expected %0d, got %0d", want.suf_base, got.suf_base);
				errors++;
			end
			if (got.pre_base !== want.pre_base) begin
				$error("prefix_base: expected %0d, got %0d", want.pre_base, got.pre_base);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_result: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] seq_byte;
	logic [LEN_W-1:0]  seq_length;
	logic [LEN_W-1:0]  split_position;
	logic              last_byte;
	logic              out_valid;
	logic              out_ready;
	logic [LEN_W-1:0]  prefix_length;
	logic [LEN_W-1:0]  suffix_length;
	logic [STEP_W-1:0] step_index;
	logic [BASE_W-1:0] suffix_base;
	logic [BASE_W-1:0] prefix_base;
	logic              last_result;

	outward_base_tracker tracker = new();

	bit gaps_on   = 1'b1;
	bit hold_out  = 1'b0;
	int words_out = 0;
	int quiet_cnt = 0;

	superkmer_base_interleaver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.seq_byte       (seq_byte),
		.seq_length     (seq_length),
		.split_position (split_position),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.prefix_length  (prefix_length),
		.suffix_length  (suffix_length),
		.step_index     (step_index),
		.suffix_base    (suffix_base),
		.prefix_base    (prefix_base),
		.last_result    (last_result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// monitors see pre-edge values, flops update later in the step
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			tracker.take_byte(seq_byte, seq_length, split_position, last_byte);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_step({prefix_length, suffix_length, step_index,
				suffix_base, prefix_base, last_result});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cnt <= 0;
			else
				quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_out = 1'b0;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
			input logic [LEN_W-1:0] sp, input logic last);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid       <= 1'b1;
		seq_byte       <= b;
		seq_length     <= len;
		split_position <= sp;
		last_byte      <= last;
		do
			@(posedge clk);
		while (!in_ready);
		words_out++;
	endtask

	// length and split only count on the first word, later words carry noise there
	task automatic send_record(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] sp,
			input int n_words, input logic [BYTE_W-1:0] fill, input bit rand_bytes);
		logic [BYTE_W-1:0] b;
		for (int k = 0; k < n_words; k++) begin
			b = rand_bytes ? BYTE_W'($urandom) : fill;
			if (k == 0)
				send_word(b, len, sp, n_words == 1);
			else
				send_word(b, LEN_W'($urandom), LEN_W'($urandom), k == n_words - 1);
		end
	endtask

	initial begin
		int unsigned len;
		int unsigned sp;
		int          n_words;
		int          kind;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		seq_byte       = '0;
		seq_length     = '0;
		split_position = '0;
		last_byte      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single bases on each side, empty record, oversize length and split
		// with missing words, split past the end, full-size records
		send_record(7'd1, 7'd0, 1, 8'hFF, 1'b0);
		send_record(7'd1, 7'd1, 1, 8'h02, 1'b0);
		send_record(7'd0, 7'd0, 1, 8'hA5, 1'b0);
		send_record(7'd127, 7'd127, 1, 8'hE4, 1'b0);
		send_record(7'd6, 7'd9, 2, 8'h5A, 1'b0);
		send_record(7'd64, 7'd32, 16, 8'h1B, 1'b0);
		send_record(7'd64, 7'd0, 16, 8'h00, 1'b0);

		// fill the block while the receiver holds off
		hold_out = 1'b1;
		words_out = 0;
		while (words_out < RANDOM_WORDS) begin
			if (words_out >= QUIET_FROM)
				gaps_on = 1'b0;
			kind = $urandom_range(0, 9);
			len  = $urandom_range(1, MAX_BASES_DEF);
			sp   = $urandom_range(0, len);
			n_words = (len + 3) / 4;
			case (kind)
				7: begin
					len = $urandom_range(0, 127);
					sp  = $urandom_range(0, 127);
					n_words = $urandom_range(1, 20);
				end
				8: n_words = $urandom_range(1, n_words);
				9: n_words = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
				default: ;
			endcase
			send_record(LEN_W'(len), LEN_W'(sp), n_words, '0, 1'b1);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (tracker.pending_steps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_steps.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
